// ----- sv/pwms_pkg.sv -----
// Package for the positional word-match suggester.
// Defaults, request and register codes, sequencer states and field widths.
// No dependencies.
`timescale 1ns / 1ps

package pwms_pkg;

	localparam int MAX_WORDS_DEF = 64;
	localparam int MAX_LEN_DEF   = 32;

	localparam int CHAR_W   = 16;
	localparam int REQ_W    = 3;
	localparam int IDX_W    = 6;
	localparam int CNT_W    = 6;
	localparam int TOL_W    = 5;
	localparam int RATIO_W  = 4;
	localparam int CFG_AW   = 2;
	localparam int CFG_DW   = 5;
	localparam int OUT_DW   = 16;
	localparam int OUT_UW   = 2;

	localparam logic [TOL_W-1:0]   TOL_RST = 5'd1;
	localparam logic [RATIO_W-1:0] NUM_RST = 4'd3;
	localparam logic [RATIO_W-1:0] DEN_RST = 4'd5;

	typedef enum logic [REQ_W-1:0] {
		REQ_DCHAR  = 3'd0,
		REQ_DEND   = 3'd1,
		REQ_QCHAR  = 3'd2,
		REQ_SEARCH = 3'd3,
		REQ_CLEAR  = 3'd4
	} req_t;

	typedef enum logic [CFG_AW-1:0] {
		CFG_TOL = 2'd0,
		CFG_NUM = 2'd1,
		CFG_DEN = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LEN,
		S_CHK,
		S_RD,
		S_CMP,
		S_TEST,
		S_FLUSH
	} state_t;

endpackage

// ----- sv/pwms_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Used for the dictionary, length and query stores. No dependencies.
`timescale 1ns / 1ps

module pwms_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/positional_word_match_suggester.sv -----
// Top level of the positional word-match suggester.
// Depends on pwms_pkg and pwms_ram.
//
// Dictionary characters, word ends, query characters and clears are each taken
// in S_IDLE. A search word holds the input side for the whole scan: after it is
// accepted, each stored word has its length fetched (S_LEN) and checked (S_CHK);
// each word whose length is within tolerance then has every compared character
// read (S_RD) and compared (S_CMP), followed by the ratio test (S_TEST). Once
// the end of the list is found, S_FLUSH hands over the final result and the
// block returns to S_IDLE for the next input word.
// The scan's pace is set by the single read port of the character memories,
// which a single compare unit walks one position at a time. The scan also pauses
// while a result waits in the output register and another is ready to go.
// Results of a search come out in load order, the final one with tlast; no
// match gives a single result with matched low. No clearing pass is needed.
`timescale 1ns / 1ps

module positional_word_match_suggester #(
	parameter int MAX_WORDS = pwms_pkg::MAX_WORDS_DEF,
	parameter int MAX_LEN   = pwms_pkg::MAX_LEN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pwms_pkg::CFG_AW-1:0]   cfg_addr,
	input  logic [pwms_pkg::CFG_DW-1:0]   cfg_data,
	// input words
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [pwms_pkg::CHAR_W-1:0]   s_tdata,  // char_code
	input  logic [pwms_pkg::REQ_W-1:0]    s_tuser,  // req_type
	// result words
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [pwms_pkg::OUT_DW-1:0]   m_tdata,  // word_index, match_count, zero pad
	output logic [pwms_pkg::OUT_UW-1:0]   m_tuser,  // matched, overflow
	output logic                          m_tlast
);

	import pwms_pkg::*;

	localparam int IW   = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int WCW  = $clog2(MAX_WORDS + 1);
	localparam int LW   = $clog2(MAX_LEN + 1);
	localparam int CIW  = $clog2(MAX_LEN);
	localparam int DD   = MAX_WORDS * MAX_LEN;
	localparam int DAW  = $clog2(DD);
	localparam int BW   = $clog2(DD + 1);
	localparam int PW   = LW + RATIO_W;
	localparam int DFW  = (LW > TOL_W) ? LW : TOL_W;

	state_t state_q, state_d;

	logic [TOL_W-1:0]   tol_q;
	logic [RATIO_W-1:0] num_q, den_q;

	logic [WCW-1:0] wcnt_q;
	logic [LW-1:0]  fill_q;
	logic [LW-1:0]  qlen_q;
	logic           ovf_q;
	logic [BW-1:0]  wbase_q;

	logic [WCW-1:0] w_q;
	logic [BW-1:0]  sbase_q;
	logic [LW-1:0]  k_q, span_q, j_q, cnt_q;

	logic            pend_q;
	logic [IW-1:0]   pidx_q;
	logic [LW-1:0]   pcnt_q;

	logic             ov_q, om_q, oovf_q, olast_q;
	logic [IDX_W-1:0] oidx_q;
	logic [CNT_W-1:0] ocnt_q;

	logic acc;
	logic can_push;

	// memory ports
	logic              dch_we, len_we, q_we, len_re, chr_re;
	logic [DAW-1:0]    dch_waddr, dch_raddr;
	logic [CHAR_W-1:0] dch_rdata, q_rdata;
	logic [LW-1:0]     len_rdata;
	logic [CIW-1:0]    q_waddr;

	// scan datapath
	logic [LW-1:0]  k_rd;
	logic [DFW-1:0] diff;
	logic           cand;
	logic [LW-1:0]  span_rd;
	logic           hit;

	// push to output register
	logic             push;
	logic             push_m, push_last;
	logic [IDX_W-1:0] push_idx;
	logic [CNT_W-1:0] push_cnt;

	assign acc      = s_tvalid && s_tready;
	assign can_push = !ov_q || m_tready;
	assign s_tready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;

	assign k_rd    = len_rdata;
	assign diff    = (k_rd >= qlen_q) ? DFW'(k_rd - qlen_q) : DFW'(qlen_q - k_rd);
	assign cand    = (diff <= DFW'(tol_q));
	assign span_rd = (k_rd < qlen_q) ? k_rd : qlen_q;
	assign hit     = (PW'(cnt_q) * PW'(den_q)) > (PW'(num_q) * PW'(k_q));

	pwms_ram #(.WIDTH(CHAR_W), .DEPTH(DD)) u_dict (
		.clk   (clk),
		.we    (dch_we),
		.waddr (dch_waddr),
		.wdata (s_tdata),
		.re    (chr_re),
		.raddr (dch_raddr),
		.rdata (dch_rdata)
	);

	pwms_ram #(.WIDTH(LW), .DEPTH(MAX_WORDS)) u_len (
		.clk   (clk),
		.we    (len_we),
		.waddr (wcnt_q[IW-1:0]),
		.wdata (fill_q),
		.re    (len_re),
		.raddr (w_q[IW-1:0]),
		.rdata (len_rdata)
	);

	pwms_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_query (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_waddr),
		.wdata (s_tdata),
		.re    (chr_re),
		.raddr (j_q[CIW-1:0]),
		.rdata (q_rdata)
	);

	assign dch_waddr = DAW'(wbase_q + BW'(fill_q));
	assign dch_raddr = DAW'(sbase_q + BW'(j_q));
	assign q_waddr   = qlen_q[CIW-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc && s_tuser == REQ_SEARCH) begin
					state_d = S_LEN;
				end
			end
			S_LEN: begin
				if (w_q == wcnt_q) begin
					state_d = S_FLUSH;
				end else begin
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				if (!cand) begin
					state_d = S_LEN;
				end else if (span_rd == '0) begin
					state_d = S_TEST;
				end else begin
					state_d = S_RD;
				end
			end
			S_RD: state_d = S_CMP;
			S_CMP: begin
				if (j_q + LW'(1) == span_q) begin
					state_d = S_TEST;
				end else begin
					state_d = S_RD;
				end
			end
			S_TEST: begin
				if (!(hit && pend_q && !can_push)) begin
					state_d = S_LEN;
				end
			end
			S_FLUSH: begin
				if (can_push) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		dch_we    = 1'b0;
		len_we    = 1'b0;
		q_we      = 1'b0;
		len_re    = 1'b0;
		chr_re    = 1'b0;
		push      = 1'b0;
		push_m    = 1'b0;
		push_last = 1'b0;
		push_idx  = IDX_W'(pidx_q);
		push_cnt  = CNT_W'(pcnt_q);
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (s_tuser)
						REQ_DCHAR: dch_we = (wcnt_q < WCW'(MAX_WORDS)) &&
							(fill_q < LW'(MAX_LEN));
						REQ_DEND:  len_we = (fill_q != '0) && (wcnt_q < WCW'(MAX_WORDS));
						REQ_QCHAR: q_we = (qlen_q < LW'(MAX_LEN));
						default: ;
					endcase
				end
			end
			S_LEN: len_re = (w_q != wcnt_q);
			S_RD:  chr_re = 1'b1;
			S_TEST: begin
				push   = hit && pend_q && can_push;
				push_m = 1'b1;
			end
			S_FLUSH: begin
				push      = can_push;
				push_m    = pend_q;
				push_last = 1'b1;
				if (!pend_q) begin
					push_idx = '0;
					push_cnt = '0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tol_q   <= TOL_RST;
			num_q   <= NUM_RST;
			den_q   <= DEN_RST;
			wcnt_q  <= '0;
			fill_q  <= '0;
			qlen_q  <= '0;
			ovf_q   <= 1'b0;
			wbase_q <= '0;
			pend_q  <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_valid && cfg_ready) begin
				case (cfg_addr)
					CFG_TOL: tol_q <= cfg_data;
					CFG_NUM: num_q <= cfg_data[RATIO_W-1:0];
					CFG_DEN: den_q <= cfg_data[RATIO_W-1:0];
					default: ;
				endcase
			end

			if (state_q == S_IDLE && acc) begin
				case (s_tuser)
					REQ_DCHAR: begin
						if (dch_we) begin
							fill_q <= fill_q + LW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
					REQ_DEND: begin
						if (fill_q != '0) begin
							if (len_we) begin
								wcnt_q  <= wcnt_q + WCW'(1);
								wbase_q <= wbase_q + BW'(MAX_LEN);
							end else begin
								ovf_q <= 1'b1;
							end
							fill_q <= '0;
						end
					end
					REQ_QCHAR: begin
						if (q_we) begin
							qlen_q <= qlen_q + LW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
					REQ_SEARCH: pend_q <= 1'b0;
					REQ_CLEAR: begin
						wcnt_q  <= '0;
						fill_q  <= '0;
						ovf_q   <= 1'b0;
						wbase_q <= '0;
					end
					default: ;
				endcase
			end

			if (state_q == S_TEST && hit && state_d == S_LEN) begin
				pend_q <= 1'b1;
			end
			if (state_q == S_FLUSH && can_push) begin
				pend_q <= 1'b0;
				qlen_q <= '0;
			end

			// output register
			if (push) begin
				ov_q <= 1'b1;
			end else if (m_tready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// scan payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				w_q     <= '0;
				sbase_q <= '0;
			end
			S_CHK: begin
				k_q    <= k_rd;
				span_q <= span_rd;
				j_q    <= '0;
				cnt_q  <= '0;
				if (!cand) begin
					w_q     <= w_q + WCW'(1);
					sbase_q <= sbase_q + BW'(MAX_LEN);
				end
			end
			S_CMP: begin
				j_q <= j_q + LW'(1);
				if (dch_rdata == q_rdata) begin
					cnt_q <= cnt_q + LW'(1);
				end
			end
			S_TEST: begin
				if (state_d == S_LEN) begin
					w_q     <= w_q + WCW'(1);
					sbase_q <= sbase_q + BW'(MAX_LEN);
					if (hit) begin
						pidx_q <= w_q[IW-1:0];
						pcnt_q <= cnt_q;
					end
				end
			end
			default: ;
		endcase

		if (push) begin
			om_q    <= push_m;
			oidx_q  <= push_idx;
			ocnt_q  <= push_cnt;
			oovf_q  <= ovf_q;
			olast_q <= push_last;
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = {(OUT_DW - IDX_W - CNT_W)'(0), ocnt_q, oidx_q};
	assign m_tuser  = {oovf_q, om_q};
	assign m_tlast  = olast_q;

endmodule

// ----- test/positional_word_match_suggester_test.sv -----
// Self-checking testbench for positional_word_match_suggester.
// Loads dictionaries, runs searches through random stalls and checks each result word.
// Depends on pwms_pkg and the block's RTL only.
`timescale 1ns / 1ps

typedef struct packed {
	logic [pwms_pkg::IDX_W-1:0] word_index;
	logic                       matched;
	logic [pwms_pkg::CNT_W-1:0] match_count;
	logic                       overflow;
	logic                       last;
} suggestion_t;

class suggestion_board;
	logic [pwms_pkg::CHAR_W-1:0] dict_char [pwms_pkg::MAX_WORDS_DEF][pwms_pkg::MAX_LEN_DEF];
	int unsigned dict_len [pwms_pkg::MAX_WORDS_DEF];
	logic [pwms_pkg::CHAR_W-1:0] query_char [pwms_pkg::MAX_LEN_DEF];
	int unsigned words_stored, fill_len, query_len;
	bit overflow_flag;
	int unsigned tolerance, ratio_num, ratio_den;
	suggestion_t suggestions_due [$];
	int unsigned mismatches, searches, results, matches_seen, overflow_results, peak_words;

	function new();
		tolerance = pwms_pkg::TOL_RST;
		ratio_num = pwms_pkg::NUM_RST;
		ratio_den = pwms_pkg::DEN_RST;
	endfunction

	function void set_reg(pwms_pkg::cfg_idx_t idx, logic [pwms_pkg::CFG_DW-1:0] val);
		case (idx)
		pwms_pkg::CFG_TOL: tolerance = val[pwms_pkg::TOL_W-1:0];
		pwms_pkg::CFG_NUM: ratio_num = val[pwms_pkg::RATIO_W-1:0];
		pwms_pkg::CFG_DEN: ratio_den = val[pwms_pkg::RATIO_W-1:0];
		default: ;
		endcase
	endfunction

	function void note_input(logic [pwms_pkg::REQ_W-1:0] req, logic [pwms_pkg::CHAR_W-1:0] ch);
		int unsigned w, j, span, gap, hits;
		suggestion_t s;
		suggestion_t found [$];
		case (req)
		pwms_pkg::REQ_DCHAR: begin
			if (words_stored >= pwms_pkg::MAX_WORDS_DEF || fill_len >= pwms_pkg::MAX_LEN_DEF) begin
				overflow_flag = 1;
			end else begin
				dict_char[words_stored][fill_len] = ch;
				fill_len++;
			end
		end
		pwms_pkg::REQ_DEND: begin
			if (fill_len != 0) begin
				if (words_stored >= pwms_pkg::MAX_WORDS_DEF) begin
					overflow_flag = 1;
				end else begin
					dict_len[words_stored] = fill_len;
					words_stored++;
					if (words_stored > peak_words)
						peak_words = words_stored;
				end
				fill_len = 0;
			end
		end
		pwms_pkg::REQ_QCHAR: begin
			if (query_len >= pwms_pkg::MAX_LEN_DEF) begin
				overflow_flag = 1;
			end else begin
				query_char[query_len] = ch;
				query_len++;
			end
		end
		pwms_pkg::REQ_SEARCH: begin
			searches++;
			for (w = 0; w < words_stored; w++) begin
				gap = (dict_len[w] > query_len) ? dict_len[w] - query_len : query_len - dict_len[w];
				if (gap <= tolerance) begin
					span = (dict_len[w] < query_len) ? dict_len[w] : query_len;
					hits = 0;
					for (j = 0; j < span; j++)
						if (dict_char[w][j] == query_char[j])
							hits++;
					if (hits * ratio_den > ratio_num * dict_len[w]) begin
						s.word_index = pwms_pkg::IDX_W'(w);
						s.matched = 1'b1;
						s.match_count = pwms_pkg::CNT_W'(hits);
						s.overflow = overflow_flag;
						s.last = 1'b0;
						found = {found, s};
					end
				end
			end
			if (found.size() == 0) begin
				s = '0;
				s.overflow = overflow_flag;
				s.last = 1'b1;
				suggestions_due = {suggestions_due, s};
			end else begin
				foreach (found[i]) begin
					s = found[i];
					s.last = (i == found.size() - 1);
					suggestions_due = {suggestions_due, s};
				end
			end
			query_len = 0;
		end
		pwms_pkg::REQ_CLEAR: begin
			words_stored = 0;
			fill_len = 0;
			overflow_flag = 0;
		end
		default: ;
		endcase
	endfunction

	task report(string what);
		mismatches++;
		$display("MISMATCH at %0t: %s", $time, what);
	endtask

	task check_result(logic [pwms_pkg::OUT_DW-1:0] data, logic [pwms_pkg::OUT_UW-1:0] user,
			logic tlast);
		suggestion_t want;
		logic [pwms_pkg::IDX_W-1:0] idx;
		logic [pwms_pkg::CNT_W-1:0] cnt;
		results++;
		idx = data[pwms_pkg::IDX_W-1:0];
		cnt = data[pwms_pkg::IDX_W +: pwms_pkg::CNT_W];
		if (user[0] === 1'b1)
			matches_seen++;
		if (user[1] === 1'b1)
			overflow_results++;
		if (suggestions_due.size() == 0) begin
			report($sformatf("result word (index %0d) with no search pending", idx));
		end else begin
			want = suggestions_due.pop_front();
			if (idx !== want.word_index)
				report($sformatf("word_index %0d, expected %0d", idx, want.word_index));
			if (user[0] !== want.matched)
				report($sformatf("matched %b, expected %b", user[0], want.matched));
			if (cnt !== want.match_count)
				report($sformatf("match_count %0d, expected %0d", cnt, want.match_count));
			if (user[1] !== want.overflow)
				report($sformatf("overflow %b, expected %b", user[1], want.overflow));
			if (tlast !== want.last)
				report($sformatf("tlast %b, expected %b", tlast, want.last));
		end
	endtask
endclass

module positional_word_match_suggester_test;
	import pwms_pkg::*;

	localparam int CYCLE_LIMIT     = 1000000;
	localparam int SETTLE_CYCLES   = 16;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 20;
	localparam int HOLD_PHASE      = 5;
	localparam int FILL_PHASE      = 3;
	localparam int HOLD_CYCLES     = 400;

	logic                 clk = 0;
	logic                 arst_n = 0;
	logic                 cfg_valid = 0;
	logic                 cfg_ready;
	logic [CFG_AW-1:0]    cfg_addr = '0;
	logic [CFG_DW-1:0]    cfg_data = '0;
	logic                 s_tvalid = 0;
	logic                 s_tready;
	logic [CHAR_W-1:0]    s_tdata = '0;
	logic [REQ_W-1:0]     s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 0;
	logic [OUT_DW-1:0]    m_tdata;
	logic [OUT_UW-1:0]    m_tuser;
	logic                 m_tlast;

	suggestion_board sb;
	int unsigned cycles = 0;
	int unsigned sent_items = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;

	positional_word_match_suggester dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due", cycles,
				sb.suggestions_due.size());
			$display("positional_word_match_suggester_test: FAIL");
			$finish;
		end
	end

	// result side: check, then pick next tready
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata, m_tuser, m_tlast);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	function automatic logic [CHAR_W-1:0] pick_char();
		case ($urandom_range(7))
		0: return 16'h0000;
		1: return 16'hFFFF;
		2, 3: return CHAR_W'($urandom());
		default: return 16'h0041 + CHAR_W'($urandom_range(2));
		endcase
	endfunction

	task automatic send_word(input logic [REQ_W-1:0] req, input logic [CHAR_W-1:0] ch);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= ch;
		do @(posedge clk); while (!s_tready);
		sb.note_input(req, ch);
		sent_items++;
	endtask

	// leaves cfg_valid high; set_config drops it after the last write
	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
	endtask

	task automatic set_config(input int tol, input int num, input int den);
		write_reg(CFG_TOL, CFG_DW'(tol));
		write_reg(CFG_NUM, CFG_DW'(num));
		write_reg(CFG_DEN, CFG_DW'(den));
		cfg_valid <= 1'b0;
	endtask

	// hold input idle until every result is back, then let the block settle
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.suggestions_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic dict_word(input int len);
		for (int j = 0; j < len; j++)
			send_word(REQ_DCHAR, pick_char());
		send_word(REQ_DEND, CHAR_W'($urandom()));
	endtask

	task automatic query_search(input int len, input int base);
		logic [CHAR_W-1:0] ch;
		for (int j = 0; j < len; j++) begin
			if (base >= 0 && j < int'(sb.dict_len[base]) && $urandom_range(3) != 0)
				ch = sb.dict_char[base][j];
			else
				ch = pick_char();
			send_word(REQ_QCHAR, ch);
		end
		send_word(REQ_SEARCH, CHAR_W'($urandom()));
	endtask

	task automatic random_sequence();
		int pick, len, base;
		pick = $urandom_range(99);
		if (pick < 35) begin
			if ($urandom_range(9) == 0)
				len = $urandom_range(MAX_LEN_DEF + 2, 7);
			else
				len = $urandom_range(6, 1);
			dict_word(len);
		end else if (pick < 75 && sb.words_stored != 0) begin
			base = $urandom_range(sb.words_stored - 1);
			len = int'(sb.dict_len[base]) + int'($urandom_range(4)) - 2;
			if (len < 0)
				len = 0;
			query_search(len, base);
		end else if (pick < 85) begin
			query_search($urandom_range(MAX_LEN_DEF + 2), -1);
		end else if (pick < 96) begin
			repeat ($urandom_range(4, 1))
				send_word(REQ_W'($urandom()), CHAR_W'($urandom()));
		end else begin
			send_word(REQ_CLEAR, CHAR_W'($urandom()));
		end
	endtask

	// long word and query past the length limit, then a full dictionary
	task automatic fill_dictionary();
		send_word(REQ_CLEAR, CHAR_W'($urandom()));
		dict_word(MAX_LEN_DEF + 2);
		query_search(MAX_LEN_DEF + 2, 0);
		for (int i = 0; i < MAX_WORDS_DEF + 2; i++)
			dict_word(1);
		query_search(1, -1);
		query_search(2, $urandom_range(MAX_WORDS_DEF - 1));
	endtask

	task automatic directed_words();
		logic [REQ_W-1:0] spare;
		send_word(REQ_CLEAR, 16'h0000);
		send_word(REQ_DCHAR, 16'h0000);
		send_word(REQ_DCHAR, 16'hFFFF);
		send_word(REQ_DEND, 16'hFFFF);
		send_word(REQ_DEND, 16'h0000);
		send_word(REQ_DCHAR, 16'hA5A5);
		send_word(REQ_DCHAR, 16'h5A5A);
		send_word(REQ_DCHAR, 16'hFFFF);
		send_word(REQ_DEND, 16'h5A5A);
		send_word(REQ_QCHAR, 16'h0000);
		send_word(REQ_QCHAR, 16'hFFFF);
		send_word(REQ_SEARCH, 16'hA5A5);
		send_word(REQ_QCHAR, 16'h1234);
		send_word(REQ_SEARCH, 16'h0000);
		send_word(REQ_SEARCH, 16'hFFFF);
		for (int r = int'(REQ_CLEAR) + 1; r < (1 << REQ_W); r++) begin
			spare = REQ_W'(r);
			send_word(spare, 16'hFFFF);
		end
		// query in progress survives a clear; search of an empty dictionary
		send_word(REQ_QCHAR, 16'hA5A5);
		send_word(REQ_CLEAR, 16'hFFFF);
		send_word(REQ_QCHAR, 16'h5A5A);
		send_word(REQ_SEARCH, 16'h0000);
	endtask

	initial begin
		int unsigned target;
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_words();
		for (int p = 0; p < PHASES; p++) begin
			drain();
			case (p)
			0: ;
			1: set_config(0, 0, 1);
			2: set_config(31, 15, 15);
			3: set_config(2, 1, 2);
			4: set_config(1, 0, 0);
			default: set_config($urandom_range(3), $urandom_range(15), $urandom_range(15, 1));
			endcase
			case (p % 4)
			0: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			1: begin
				send_idle_pct = 47;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				recv_stall_pct = 47;
			end
			default: begin
				send_idle_pct = 23;
				recv_stall_pct = 23;
			end
			endcase
			if (p == HOLD_PHASE)
				hold_req <= hold_req + 1;
			if (p == FILL_PHASE)
				fill_dictionary();
			target = sent_items + ITEMS_PER_PHASE;
			while (sent_items < target)
				random_sequence();
		end
		drain();
		$display("Ran %0d input words over %0d settings: %0d searches, %0d result words",
			sent_items, PHASES, sb.searches, sb.results);
		$display("%0d suggestions, %0d flagged overflow, dictionary peaked at %0d words",
			sb.matches_seen, sb.overflow_results, sb.peak_words);
		if (sb.mismatches == 0) begin
			$display("positional_word_match_suggester_test: PASS");
		end else begin
			$display("%0d mismatches", sb.mismatches);
			$display("positional_word_match_suggester_test: FAIL");
		end
		$finish;
	end

endmodule
